// ===== hw/rtl/udf_pkg.sv =====
package udf_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int FIELD_WIDTH  = 6;
   localparam int MODE_WIDTH   = 2;
   localparam int CHAR_WIDTH   = 8;
   localparam int COUNT_WIDTH  = 6;
   localparam int REMAIN_WIDTH = 8;

   localparam int DEFAULT_VALUE_BITS  = 64;
   localparam int DEFAULT_FIELD_LIMIT = 63;

   // length modes, any other code keeps the full value
   localparam logic [MODE_WIDTH-1:0] MODE_BYTE = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_WORD = 2'd2;

   localparam int BYTE_BITS = 8;
   localparam int WORD_BITS = 32;

   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;

   typedef struct packed {
      logic load;
      logic step;
      logic measure;
      logic plan;
      logic emit;
   } udf_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic empty;
      logic emit_last;
      logic out_free;
   } udf_status_type;

endpackage

// ===== hw/rtl/udf_req_if.sv =====
interface udf_req_if;
   logic                                valid;
   logic                                ready;
   logic [udf_pkg::VALUE_WIDTH-1:0]     value;
   logic [udf_pkg::FIELD_WIDTH-1:0]     min_width;
   logic                                has_precision;
   logic [udf_pkg::FIELD_WIDTH-1:0]     precision;
   logic                                left_justify;
   logic                                zero_pad;
   logic [udf_pkg::MODE_WIDTH-1:0]      length_mode;

   modport source (
      output valid, value, min_width, has_precision, precision, left_justify, zero_pad,
             length_mode,
      input  ready
   );

   modport sink (
      input  valid, value, min_width, has_precision, precision, left_justify, zero_pad,
             length_mode,
      output ready
   );
endinterface

// ===== hw/rtl/udf_rsp_if.sv =====
interface udf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [udf_pkg::CHAR_WIDTH-1:0]   character;
   logic                             last;

   modport source (
      output valid, character, last,
      input  ready
   );

   modport sink (
      input  valid, character, last,
      output ready
   );
endinterface

// ===== hw/rtl/udf_controller.sv =====
module udf_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output udf_pkg::udf_cmd_type     cmd,
   input  udf_pkg::udf_status_type  status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_PLAN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
               ready_in = 1'b0;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
            state_in    = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.empty) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// ===== hw/rtl/udf_datapath.sv =====
module udf_datapath #(
   parameter int VALUE_BITS  = udf_pkg::DEFAULT_VALUE_BITS,
   parameter int FIELD_LIMIT = udf_pkg::DEFAULT_FIELD_LIMIT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  udf_pkg::udf_cmd_type               cmd,
   output udf_pkg::udf_status_type            status,
   input  logic [udf_pkg::VALUE_WIDTH-1:0]    req_value,
   input  logic [udf_pkg::FIELD_WIDTH-1:0]    req_min_width,
   input  logic                               req_has_precision,
   input  logic [udf_pkg::FIELD_WIDTH-1:0]    req_precision,
   input  logic                               req_left_justify,
   input  logic                               req_zero_pad,
   input  logic [udf_pkg::MODE_WIDTH-1:0]     req_length_mode,
   udf_rsp_if.source                          rsp_chan
);

   localparam int DIGITS    = VALUE_BITS * 30103 / 100000 + 1;
   localparam int NDIG_BITS = $clog2(DIGITS + 1);
   localparam int IDX_BITS  = $clog2(DIGITS);
   localparam int STEP_BITS = $clog2(VALUE_BITS + 1);
   localparam int CW        = udf_pkg::COUNT_WIDTH;
   localparam int FW        = udf_pkg::FIELD_WIDTH;
   localparam int RW        = udf_pkg::REMAIN_WIDTH;

   logic [VALUE_BITS-1:0]         value_ff, value_in;
   logic [3:0]                    digit_ff [DIGITS];
   logic [3:0]                    digit_in [DIGITS];
   logic [3:0]                    adjusted [DIGITS];
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [FW-1:0]                 width_ff, width_in;
   logic [FW-1:0]                 prec_ff, prec_in;
   logic                          has_prec_ff, has_prec_in;
   logic                          left_ff, left_in;
   logic                          zero_ff, zero_in;
   logic [NDIG_BITS-1:0]          ndig_ff, ndig_in;
   logic [CW-1:0]                 lead_ff, lead_in;
   logic [CW-1:0]                 zcnt_ff, zcnt_in;
   logic [NDIG_BITS-1:0]          dig_ff, dig_in;
   logic [CW-1:0]                 trail_ff, trail_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [udf_pkg::CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0]         masked;
   logic [NDIG_BITS-1:0]          top_digit;
   logic [CW-1:0]                 ndig_ext;
   logic [CW-1:0]                 zeros_calc;
   logic [CW:0]                   filled;
   logic [CW-1:0]                 spaces_calc;
   logic [RW-1:0]                 remain;
   logic [IDX_BITS-1:0]           dig_idx;

   // length mode truncation
   always_comb begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         unique case (req_length_mode)
            udf_pkg::MODE_BYTE: masked[i] = req_value[i] && (i < udf_pkg::BYTE_BITS);
            udf_pkg::MODE_WORD: masked[i] = req_value[i] && (i < udf_pkg::WORD_BITS);
            default:            masked[i] = req_value[i];
         endcase
      end
   end

   // shift-add-3 adjust per digit
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adjusted[d] = (digit_ff[d] >= 4'd5) ? digit_ff[d] + 4'd3 : digit_ff[d];
      end
   end

   // highest nonzero digit
   always_comb begin
      top_digit = '0;
      for (int d = 0; d < DIGITS; d++) begin
         if (digit_ff[d] != 4'd0) begin
            top_digit = NDIG_BITS'(d + 1);
         end
      end
   end

   assign ndig_ext = CW'(ndig_ff);

   always_comb begin
      zeros_calc = '0;
      if (has_prec_ff) begin
         if (prec_ff > ndig_ext) begin
            zeros_calc = prec_ff - ndig_ext;
         end
      end else if (!left_ff && zero_ff) begin
         if (width_ff > ndig_ext) begin
            zeros_calc = width_ff - ndig_ext;
         end
      end
      filled      = {1'b0, zeros_calc} + {1'b0, ndig_ext};
      spaces_calc = ({1'b0, width_ff} > filled) ? CW'({1'b0, width_ff} - filled) : '0;
   end

   assign remain  = RW'(lead_ff) + RW'(zcnt_ff) + RW'(dig_ff) + RW'(trail_ff);
   assign dig_idx = IDX_BITS'(dig_ff - 1'b1);

   always_comb begin
      value_in     = value_ff;
      digit_in     = digit_ff;
      step_in      = step_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      has_prec_in  = has_prec_ff;
      left_in      = left_ff;
      zero_in      = zero_ff;
      ndig_in      = ndig_ff;
      lead_in      = lead_ff;
      zcnt_in      = zcnt_ff;
      dig_in       = dig_ff;
      trail_in     = trail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         value_in    = masked;
         for (int d = 0; d < DIGITS; d++) begin
            digit_in[d] = 4'd0;
         end
         step_in     = STEP_BITS'(VALUE_BITS);
         width_in    = (req_min_width > FW'(FIELD_LIMIT)) ? FW'(FIELD_LIMIT) : req_min_width;
         prec_in     = (req_precision > FW'(FIELD_LIMIT)) ? FW'(FIELD_LIMIT) : req_precision;
         has_prec_in = req_has_precision;
         left_in     = req_left_justify;
         zero_in     = req_zero_pad;
      end

      if (cmd.step) begin
         digit_in[0] = {adjusted[0][2:0], value_ff[VALUE_BITS-1]};
         for (int d = 1; d < DIGITS; d++) begin
            digit_in[d] = {adjusted[d][2:0], adjusted[d-1][3]};
         end
         value_in = {value_ff[VALUE_BITS-2:0], 1'b0};
         step_in  = step_ff - 1'b1;
      end

      if (cmd.measure) begin
         if (top_digit != '0) begin
            ndig_in = top_digit;
         end else if (has_prec_ff && prec_ff == '0) begin
            ndig_in = '0;
         end else begin
            ndig_in = NDIG_BITS'(1);
         end
      end

      if (cmd.plan) begin
         lead_in  = left_ff ? '0 : spaces_calc;
         trail_in = left_ff ? spaces_calc : '0;
         zcnt_in  = zeros_calc;
         dig_in   = ndig_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (remain == RW'(1));
         if (lead_ff != '0) begin
            rsp_char_in = udf_pkg::CHAR_SPACE;
            lead_in     = lead_ff - 1'b1;
         end else if (zcnt_ff != '0) begin
            rsp_char_in = udf_pkg::CHAR_ZERO;
            zcnt_in     = zcnt_ff - 1'b1;
         end else if (dig_ff != '0) begin
            rsp_char_in = udf_pkg::CHAR_ZERO + udf_pkg::CHAR_WIDTH'(digit_ff[dig_idx]);
            dig_in      = dig_ff - 1'b1;
         end else begin
            rsp_char_in = udf_pkg::CHAR_SPACE;
            trail_in    = trail_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      digit_ff    <= digit_in;
      step_ff     <= step_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      has_prec_ff <= has_prec_in;
      left_ff     <= left_in;
      zero_ff     <= zero_in;
      ndig_ff     <= ndig_in;
      lead_ff     <= lead_in;
      zcnt_ff     <= zcnt_in;
      dig_ff      <= dig_in;
      trail_ff    <= trail_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.conv_done = (step_ff == STEP_BITS'(1));
   assign status.empty     = (remain == '0);
   assign status.emit_last = (remain == RW'(1));
   assign status.out_free  = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

// ===== hw/rtl/unsigned_decimal_formatter.sv =====
// channel    direction  handshake      payload
// req_chan   in         valid/ready    value, min_width, has_precision, precision,
//                                      left_justify, zero_pad, length_mode
// rsp_chan   out        valid/ready    character, last
//
// a request is converted by the binary to bcd shift loop, then measured and planned, then
// emitted character by character, 0 to 63 characters
// the next request is taken the cycle after its last character enters the output register
// an empty text still passes through the emit state, with nothing sent
// reset is synchronous and active high; it clears the controller and the output valid
// a low rsp ready holds the current character and pauses emission, no request is lost
module unsigned_decimal_formatter #(
   parameter int VALUE_BITS  = udf_pkg::DEFAULT_VALUE_BITS,
   parameter int FIELD_LIMIT = udf_pkg::DEFAULT_FIELD_LIMIT
) (
   input  logic       clock,
   input  logic       reset,
   udf_req_if.sink    req_chan,
   udf_rsp_if.source  rsp_chan
);

   udf_pkg::udf_cmd_type     cmd;
   udf_pkg::udf_status_type  status;
   logic                     req_ready;

   assign req_chan.ready = req_ready;

   udf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   udf_datapath #(
      .VALUE_BITS  (VALUE_BITS),
      .FIELD_LIMIT (FIELD_LIMIT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_chan.value),
      .req_min_width     (req_chan.min_width),
      .req_has_precision (req_chan.has_precision),
      .req_precision     (req_chan.precision),
      .req_left_justify  (req_chan.left_justify),
      .req_zero_pad      (req_chan.zero_pad),
      .req_length_mode   (req_chan.length_mode),
      .rsp_chan          (rsp_chan)
   );

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.measure, cmd.plan, cmd.emit}))
      else $error("more than one datapath command");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("character emitted over a waiting one");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_chan.ready)
      else $error("request taken during conversion");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.emit_last) |=> req_chan.ready)
      else $error("not ready after last character");

endmodule

// ===== tb/unsigned_decimal_formatter_tb.sv =====
module unsigned_decimal_formatter_tb;

   localparam int FIELD_LIMIT  = udf_pkg::DEFAULT_FIELD_LIMIT;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 200;

   localparam logic [udf_pkg::MODE_WIDTH-1:0] MODE_FULL  = 2'd0;
   localparam logic [udf_pkg::MODE_WIDTH-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [udf_pkg::VALUE_WIDTH-1:0] value;
      logic [udf_pkg::FIELD_WIDTH-1:0] min_width;
      logic                            has_precision;
      logic [udf_pkg::FIELD_WIDTH-1:0] precision;
      logic                            left_justify;
      logic                            zero_pad;
      logic [udf_pkg::MODE_WIDTH-1:0]  length_mode;
   } format_request_type;

   typedef struct packed {
      logic [udf_pkg::CHAR_WIDTH-1:0] character;
      logic                           last;
   } text_char_type;

   logic clock;
   logic reset;

   udf_req_if req_chan();
   udf_rsp_if rsp_chan();

   unsigned_decimal_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   format_request_type directed_rows[$];
   bit                 directed_typed[$];
   string              directed_text[$];

   text_char_type pending_chars[$];

   int mismatches    = 0;
   int requests_sent = 0;
   int empty_texts   = 0;
   int chars_checked = 0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #25_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // decimal text of one request, character by character
   function automatic string render_decimal(format_request_type r);
      logic [udf_pkg::VALUE_WIDTH-1:0] magnitude;
      int width;
      int prec;
      int zeros;
      int spaces;
      string digits;
      string text;
      magnitude = r.value;
      if (r.length_mode == udf_pkg::MODE_BYTE)
         magnitude = udf_pkg::VALUE_WIDTH'(r.value[udf_pkg::BYTE_BITS-1:0]);
      else if (r.length_mode == udf_pkg::MODE_WORD)
         magnitude = udf_pkg::VALUE_WIDTH'(r.value[udf_pkg::WORD_BITS-1:0]);
      width = (r.min_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(r.min_width);
      prec  = (r.precision > FIELD_LIMIT) ? FIELD_LIMIT : int'(r.precision);
      if (magnitude == '0 && r.has_precision && prec == 0)
         digits = "";
      else
         digits = $sformatf("%0d", magnitude);
      zeros = 0;
      if (r.has_precision) begin
         if (prec > digits.len())
            zeros = prec - digits.len();
      end else if (!r.left_justify && r.zero_pad && width > digits.len()) begin
         zeros = width - digits.len();
      end
      spaces = (width > zeros + digits.len()) ? width - zeros - digits.len() : 0;
      text = "";
      if (!r.left_justify)
         repeat (spaces) text = {text, " "};
      repeat (zeros) text = {text, "0"};
      text = {text, digits};
      if (r.left_justify)
         repeat (spaces) text = {text, " "};
      return text;
   endfunction

   task automatic queue_text(string text);
      text_char_type c;
      for (int k = 0; k < text.len(); k++) begin
         c.character = text[k];
         c.last      = (k == text.len() - 1);
         pending_chars.push_back(c);
      end
   endtask

   task automatic add_row(logic [udf_pkg::VALUE_WIDTH-1:0] value, int width, int has_prec,
                          int prec, int left, int zero, logic [udf_pkg::MODE_WIDTH-1:0] mode,
                          int typed, string text);
      format_request_type r;
      r.value         = value;
      r.min_width     = udf_pkg::FIELD_WIDTH'(width);
      r.has_precision = (has_prec != 0);
      r.precision     = udf_pkg::FIELD_WIDTH'(prec);
      r.left_justify  = (left != 0);
      r.zero_pad      = (zero != 0);
      r.length_mode   = mode;
      directed_rows.push_back(r);
      directed_typed.push_back(typed != 0);
      directed_text.push_back(text);
   endtask

   function automatic int idle_span();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic int sender_gap();
      if ($urandom_range(0, 99) < send_gap_pct)
         return idle_span();
      return 0;
   endfunction

   function automatic logic [udf_pkg::VALUE_WIDTH-1:0] random_value();
      logic [udf_pkg::VALUE_WIDTH-1:0] p;
      int k;
      case ($urandom_range(0, 5))
         0: return {$urandom, $urandom};
         1: return udf_pkg::VALUE_WIDTH'($urandom_range(0, 999));
         2: return '0;
         3: begin
            p = 1;
            k = $urandom_range(0, 19);
            repeat (k) p = p * 10;
            return $urandom_range(0, 1) ? p : p - 1;
         end
         4: return '1 - udf_pkg::VALUE_WIDTH'($urandom_range(0, 3));
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [udf_pkg::FIELD_WIDTH-1:0] random_field();
      if ($urandom_range(0, 99) < 80)
         return udf_pkg::FIELD_WIDTH'($urandom_range(0, 24));
      return udf_pkg::FIELD_WIDTH'($urandom_range(25, 63));
   endfunction

   function automatic format_request_type random_request();
      format_request_type r;
      r.value         = random_value();
      r.min_width     = random_field();
      r.has_precision = 1'($urandom_range(0, 1));
      r.precision     = random_field();
      r.left_justify  = 1'($urandom_range(0, 1));
      r.zero_pad      = 1'($urandom_range(0, 1));
      r.length_mode   = udf_pkg::MODE_WIDTH'($urandom_range(0, 3));
      return r;
   endfunction

   // called at a rising edge; a zero gap keeps valid high from the previous request
   task automatic send_request(format_request_type item, string text, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.value         <= item.value;
      req_chan.min_width     <= item.min_width;
      req_chan.has_precision <= item.has_precision;
      req_chan.precision     <= item.precision;
      req_chan.left_justify  <= item.left_justify;
      req_chan.zero_pad      <= item.zero_pad;
      req_chan.length_mode   <= item.length_mode;
      req_chan.valid         <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      queue_text(text);
      requests_sent++;
      if (text.len() == 0)
         empty_texts++;
   endtask

   task automatic flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            flag_mismatch($sformatf("unexpected character 8'h%02h last %0b",
                                    rsp_chan.character, rsp_chan.last));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_chan.character !== want.character || rsp_chan.last !== want.last)
               flag_mismatch($sformatf(
                  "character %0d: expected 8'h%02h last %0b, got 8'h%02h last %0b",
                  chars_checked, want.character, want.last,
                  rsp_chan.character, rsp_chan.last));
         end
         chars_checked++;
      end
   end

   initial begin
      int hold;
      hold           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 99) < rsp_stall_pct)
               hold = idle_span();
         end
      end
   end

   initial begin
      format_request_type item;
      string text;
      int n;
      int pct_choice[3];

      pct_choice[0] = 0;
      pct_choice[1] = 20;
      pct_choice[2] = 60;

      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.value         = '0;
      req_chan.min_width     = '0;
      req_chan.has_precision = 1'b0;
      req_chan.precision     = '0;
      req_chan.left_justify  = 1'b0;
      req_chan.zero_pad      = 1'b0;
      req_chan.length_mode   = MODE_FULL;

      add_row(64'd0, 0, 0, 0, 0, 0, MODE_FULL, 1, "0");
      add_row(64'd0, 0, 1, 0, 0, 0, MODE_FULL, 1, "");
      add_row(64'd0, 3, 1, 0, 0, 0, MODE_FULL, 1, "   ");
      add_row(64'd0, 3, 1, 0, 1, 0, MODE_FULL, 1, "   ");
      add_row('1, 0, 0, 0, 0, 0, MODE_FULL, 1, "18446744073709551615");
      add_row('1, 0, 0, 0, 0, 0, udf_pkg::MODE_BYTE, 1, "255");
      add_row('1, 0, 0, 0, 0, 0, udf_pkg::MODE_WORD, 1, "4294967295");
      add_row('1, 0, 0, 0, 0, 0, MODE_SPARE, 1, "18446744073709551615");
      add_row(64'h1_0000_0100, 0, 0, 0, 0, 0, udf_pkg::MODE_BYTE, 1, "0");
      add_row(64'd42, 5, 0, 0, 0, 0, MODE_FULL, 1, "   42");
      add_row(64'd42, 5, 0, 0, 1, 0, MODE_FULL, 1, "42   ");
      add_row(64'd42, 5, 0, 0, 0, 1, MODE_FULL, 1, "00042");
      add_row(64'd42, 5, 0, 0, 1, 1, MODE_FULL, 1, "42   ");
      add_row(64'd42, 0, 1, 4, 0, 0, MODE_FULL, 1, "0042");
      add_row(64'd7, 5, 1, 2, 0, 1, MODE_FULL, 1, "   07");
      add_row(64'd7, 6, 1, 3, 1, 0, MODE_FULL, 1, "007   ");
      add_row(64'd12345, 2, 0, 0, 0, 0, MODE_FULL, 1, "12345");
      add_row(64'd12345, 0, 1, 3, 0, 0, MODE_FULL, 1, "12345");
      add_row(64'd0, 0, 1, 1, 0, 0, MODE_FULL, 1, "0");
      add_row(64'd0, 4, 0, 0, 0, 1, MODE_FULL, 1, "0000");
      add_row('1, 63, 0, 0, 0, 1, MODE_FULL, 0, "");
      add_row('1, 0, 1, 63, 0, 0, udf_pkg::MODE_WORD, 0, "");
      add_row(64'd5, 63, 0, 0, 1, 0, MODE_FULL, 0, "");
      add_row(64'd1, 63, 1, 63, 1, 1, MODE_SPARE, 0, "");
      add_row(64'd99, 40, 1, 0, 0, 1, udf_pkg::MODE_BYTE, 0, "");

      send_gap_pct  = 30;
      rsp_stall_pct = 30;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < directed_rows.size(); n++) begin
         text = directed_typed[n] ? directed_text[n] : render_decimal(directed_rows[n]);
         send_request(directed_rows[n], text, sender_gap());
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            send_gap_pct  = (n == 0) ? 0 : pct_choice[$urandom_range(0, 2)];
            rsp_stall_pct = (n == 0) ? 0 : pct_choice[$urandom_range(0, 2)];
         end
         item = random_request();
         text = render_decimal(item);
         if (n == RANDOM_ITEMS / 2) begin
            // hold off until the formatter has drained every character
            req_chan.valid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge clock);
            @(posedge clock);
            send_request(item, text, 0);
         end else begin
            send_request(item, text, sender_gap());
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("formatted %0d requests (%0d with empty text), %0d characters checked",
               requests_sent, empty_texts, chars_checked);
      $display("all length modes, padding styles and precision cases, %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_chars.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/udf_pkg.sv
hw/rtl/udf_req_if.sv
hw/rtl/udf_rsp_if.sv
hw/rtl/udf_controller.sv
hw/rtl/udf_datapath.sv
hw/rtl/unsigned_decimal_formatter.sv
tb/unsigned_decimal_formatter_tb.sv
